// ===== hw/rtl/afrng_pkg.sv =====
// Shared types, constants and the power-up table of the lagged-Fibonacci generator.
`default_nettype none

package afrng_pkg;

  localparam int TABLE_DEPTH  = 55;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int WORD_W       = 32;
  localparam int COEF_W       = 10;
  localparam int TRAIL_OFFSET = 20;
  localparam int MUL_WORD     = 1001;
  localparam int MUL_SEED     = 999;
  localparam int MOD_STEPS    = 3;

  // Modulo-55 reduction: 2^20 is 1 modulo 55, and RECIP is ceil(2^27 / 55), exact
  // for every quotient of a 20-bit operand.
  localparam int FOLD_W      = 20;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 27;
  localparam int QUOT_W      = 15;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(2440323);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DR_A,
    ST_DR_B,
    ST_DR_W,
    ST_SD_ADD,
    ST_SD_WR,
    ST_SD_MIX,
    ST_MOD,
    ST_FINISH
  } afrng_state_t;

  typedef enum logic [1:0] {
    COEF_ONE,
    COEF_WORD,
    COEF_SEED
  } afrng_coef_t;

  typedef struct packed {
    logic        en;
    afrng_coef_t coef;
  } afrng_mac_ctl_t;

  function automatic logic [WORD_W-1:0] afrng_start_word(input logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] w;
    case (idx)
      6'd0:  w = 32'o35340171546;
      6'd1:  w = 32'o10401501101;
      6'd2:  w = 32'o22364657325;
      6'd3:  w = 32'o24130436022;
      6'd4:  w = 32'o02167303062;
      6'd5:  w = 32'o37570375137;
      6'd6:  w = 32'o37210607110;
      6'd7:  w = 32'o16272055420;
      6'd8:  w = 32'o23011770546;
      6'd9:  w = 32'o17143426366;
      6'd10: w = 32'o14753657433;
      6'd11: w = 32'o21657231332;
      6'd12: w = 32'o23553406142;
      6'd13: w = 32'o04236526362;
      6'd14: w = 32'o10365611275;
      6'd15: w = 32'o07117336710;
      6'd16: w = 32'o11051276551;
      6'd17: w = 32'o02362132524;
      6'd18: w = 32'o01011540233;
      6'd19: w = 32'o12162531646;
      6'd20: w = 32'o07056762337;
      6'd21: w = 32'o06631245521;
      6'd22: w = 32'o14164542224;
      6'd23: w = 32'o32633236305;
      6'd24: w = 32'o23342700176;
      6'd25: w = 32'o02433062234;
      6'd26: w = 32'o15257225043;
      6'd27: w = 32'o26762051606;
      6'd28: w = 32'o00742573230;
      6'd29: w = 32'o05366042132;
      6'd30: w = 32'o12126416411;
      6'd31: w = 32'o00520471171;
      6'd32: w = 32'o00725646277;
      6'd33: w = 32'o20116577576;
      6'd34: w = 32'o25765742604;
      6'd35: w = 32'o07633473735;
      6'd36: w = 32'o15674255275;
      6'd37: w = 32'o17555634041;
      6'd38: w = 32'o06503154145;
      6'd39: w = 32'o21576344247;
      6'd40: w = 32'o14577627653;
      6'd41: w = 32'o02707523333;
      6'd42: w = 32'o34146376720;
      6'd43: w = 32'o30060227734;
      6'd44: w = 32'o13765414060;
      6'd45: w = 32'o36072251540;
      6'd46: w = 32'o07255221037;
      6'd47: w = 32'o24364674123;
      6'd48: w = 32'o06200353166;
      6'd49: w = 32'o10126373326;
      6'd50: w = 32'o15664104320;
      6'd51: w = 32'o16401041535;
      6'd52: w = 32'o16215305520;
      6'd53: w = 32'o33115351014;
      6'd54: w = 32'o17411670323;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/afrng_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
`default_nettype none

module afrng_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 55
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/afrng_mac.sv =====
// Shared multiply-accumulate unit: result = addend + operand * constant coefficient.
`default_nettype none

module afrng_mac
  import afrng_pkg::*;
(
  input  wire logic           clk,
  input  wire afrng_mac_ctl_t ctl,
  input  wire logic [WORD_W-1:0] mult_a,
  input  wire logic [WORD_W-1:0] addend,
  output      logic [WORD_W-1:0] result_r
);

  logic [COEF_W-1:0]        coef;
  logic [WORD_W+COEF_W-1:0] prod;
  logic [WORD_W-1:0]        result_nxt;

  always_comb begin
    unique case (ctl.coef)
      COEF_ONE:  coef = COEF_W'(1);
      COEF_WORD: coef = COEF_W'(MUL_WORD);
      COEF_SEED: coef = COEF_W'(MUL_SEED);
      default:   coef = '0;
    endcase
    prod       = {{COEF_W{1'b0}}, mult_a} * {{WORD_W{1'b0}}, coef};
    result_nxt = addend + prod[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      result_r <= result_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/additive_lagged_fibonacci_rng.sv =====
// Top level of the additive lagged-Fibonacci random word generator.
// The generator keeps a 55-word table of 32-bit words in a RAM with one read
// and one write port, plus a lead and a trail index. A draw transfer (tuser 0)
// returns the sum of the two indexed words, stores it at the lead index and
// steps both indices; its two table reads go one after the other through the
// single RAM read port. A seed transfer (tuser 1, seed in tdata) walks the
// table through the one shared multiply-accumulate unit, word by word, then
// reduces word 0 modulo 55 (two folds, a reciprocal multiply, a remainder) to
// place the indices; it returns a zero word. The block takes one item at a
// time and shows in_tready only while idle; a finished result sits in an output
// register until taken, and a result that is still waiting there delays the
// next one.
// Power-up contents of the table come from a constant table through one
// valid bit per word, so no clearing pass is needed after reset.
`default_nettype none

module additive_lagged_fibonacci_rng
  import afrng_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] seed_value
  input  wire logic        in_tuser,   // [0] req_type
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata   // [31:0] random_value
);

  afrng_state_t state_r, state_nxt;

  logic [IDX_W-1:0]       lead_r, lead_nxt;
  logic [IDX_W-1:0]       trail_r, trail_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [WORD_W-1:0]      s_r, s_nxt;
  logic [WORD_W-1:0]      w0_r, w0_nxt;
  logic [WORD_W-1:0]      op_a_r, op_a_nxt;
  logic [WORD_W-1:0]      res_r, res_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [WORD_W-1:0]      out_tdata_r, out_tdata_nxt;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic                   rd_valid_r;
  logic [WORD_W-1:0]      rd_const_r;

  logic              ram_re, ram_we;
  logic [IDX_W-1:0]  ram_raddr, ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, word;
  afrng_mac_ctl_t    mac_ctl;
  logic [WORD_W-1:0] mac_a, mac_addend, mac_q;
  logic [FOLD_W:0]           fold_a;
  logic [FOLD_W-1:0]         fold_y;
  logic [FOLD_W+RECIP_W-1:0] quot_prod;
  logic [FOLD_W-1:0]         mod_prod, mod_rem;
  logic [IDX_W:0]            trail_sum;

  afrng_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  afrng_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .mult_a  (mac_a),
    .addend  (mac_addend),
    .result_r(mac_q)
  );

  // A word never written since reset still holds its power-up value.
  assign word = rd_valid_r ? ram_rdata : rd_const_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    lead_nxt       = lead_r;
    trail_nxt      = trail_r;
    idx_nxt        = idx_r;
    s_nxt          = s_r;
    w0_nxt         = w0_r;
    op_a_nxt       = op_a_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = mac_q;
    mac_ctl.en     = 1'b0;
    mac_ctl.coef   = COEF_ONE;
    mac_a          = word;
    mac_addend     = s_r;
    // The two folds keep the value modulo 55 and leave it below 2^20.
    fold_a    = {1'b0, w0_r[FOLD_W-1:0]} + (FOLD_W+1)'(w0_r[WORD_W-1:FOLD_W]);
    fold_y    = fold_a[FOLD_W-1:0] + FOLD_W'(fold_a[FOLD_W]);
    quot_prod = {{RECIP_W{1'b0}}, w0_r[FOLD_W-1:0]} * {{FOLD_W{1'b0}}, RECIP};
    mod_prod  = {{(FOLD_W-QUOT_W){1'b0}}, s_r[QUOT_W-1:0]} * FOLD_W'(TABLE_DEPTH);
    mod_rem   = w0_r[FOLD_W-1:0] - mod_prod;
    trail_sum = {1'b0, mod_rem[IDX_W-1:0]} + (IDX_W+1)'(TRAIL_OFFSET);
    if (trail_sum >= (IDX_W+1)'(TABLE_DEPTH)) begin
      trail_sum = trail_sum - (IDX_W+1)'(TABLE_DEPTH);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ram_re = 1'b1;
          if (in_tuser) begin
            s_nxt     = in_tdata;
            idx_nxt   = '0;
            ram_raddr = '0;
            state_nxt = ST_SD_ADD;
          end else begin
            ram_raddr = lead_r;
            state_nxt = ST_DR_A;
          end
        end
      end
      ST_DR_A: begin
        op_a_nxt  = word;
        ram_re    = 1'b1;
        ram_raddr = trail_r;
        state_nxt = ST_DR_B;
      end
      ST_DR_B: begin
        mac_ctl.en = 1'b1;
        mac_addend = op_a_r;
        state_nxt  = ST_DR_W;
      end
      ST_DR_W: begin
        ram_we    = 1'b1;
        ram_waddr = lead_r;
        res_nxt   = mac_q;
        lead_nxt  = (lead_r == LAST_IDX) ? '0 : lead_r + 1'b1;
        trail_nxt = (trail_r == LAST_IDX) ? '0 : trail_r + 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_SD_ADD: begin
        // From the second word on, the running seed is the last mixing result.
        if (idx_r != '0) begin
          mac_addend = mac_q;
          s_nxt      = mac_q;
        end
        mac_ctl.en = 1'b1;
        state_nxt  = ST_SD_WR;
      end
      ST_SD_WR: begin
        ram_we = 1'b1;
        if (idx_r == '0) begin
          w0_nxt = mac_q;
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_MOD;
        end else begin
          mac_ctl.en   = 1'b1;
          mac_ctl.coef = COEF_WORD;
          mac_a        = mac_q;
          mac_addend   = '0;
          ram_re       = 1'b1;
          ram_raddr    = idx_r + 1'b1;
          idx_nxt      = idx_r + 1'b1;
          state_nxt    = ST_SD_MIX;
        end
      end
      ST_SD_MIX: begin
        mac_ctl.en   = 1'b1;
        mac_ctl.coef = COEF_SEED;
        mac_a        = s_r;
        mac_addend   = mac_q;
        state_nxt    = ST_SD_ADD;
      end
      ST_MOD: begin
        // Word 0 modulo the table depth: fold, then quotient, then remainder.
        idx_nxt = idx_r + 1'b1;
        if (idx_r == '0) begin
          w0_nxt = {{(WORD_W-FOLD_W){1'b0}}, fold_y};
        end else if (idx_r != IDX_W'(MOD_STEPS - 1)) begin
          s_nxt = {{(WORD_W-QUOT_W){1'b0}}, quot_prod[RECIP_SHIFT +: QUOT_W]};
        end else begin
          lead_nxt  = mod_rem[IDX_W-1:0];
          trail_nxt = trail_sum[IDX_W-1:0];
          res_nxt   = '0;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lead_r       <= '0;
      trail_r      <= '0;
      out_tvalid_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      lead_r       <= lead_nxt;
      trail_r      <= trail_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    s_r         <= s_nxt;
    w0_r        <= w0_nxt;
    op_a_r      <= op_a_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (ram_re) begin
      rd_valid_r <= valid_r[ram_raddr];
      rd_const_r <= afrng_start_word(ram_raddr);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/afrng_chk.sv =====
// Port-level checker for the lagged-Fibonacci generator and its bind.
`default_nettype none

module afrng_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  // Every request keeps the block busy after its transfer: input ready does not return at once.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready ##1 !in_tready)
    else $error("input ready returned too early after a request transfer");

  // The block becomes ready again only together with a result on the output.
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) |-> out_tvalid)
    else $error("input ready returned without a pending result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("reset did not return the block to idle");

endmodule

bind additive_lagged_fibonacci_rng afrng_chk u_afrng_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire

// ===== test/rng_checker.sv =====
// Request codes and the scoreboard that predicts and checks the generator's output words.
`timescale 1ns / 100ps

package rng_req_pkg;

  typedef enum logic {
    REQ_DRAW = 1'b0,
    REQ_SEED = 1'b1
  } rng_req_t;

endpackage

module rng_checker
  import afrng_pkg::*;
  import rng_req_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] seed_value
  input  wire logic        in_tuser,   // [0] req_type
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,  // [31:0] random_value
  output int               fail_count,
  output int               pending_count
);

  // Power-up table, word 0 in the top bits.
  localparam logic [TABLE_DEPTH*WORD_W-1:0] START_WORDS = {
    32'o35340171546, 32'o10401501101, 32'o22364657325, 32'o24130436022, 32'o02167303062,
    32'o37570375137, 32'o37210607110, 32'o16272055420, 32'o23011770546, 32'o17143426366,
    32'o14753657433, 32'o21657231332, 32'o23553406142, 32'o04236526362, 32'o10365611275,
    32'o07117336710, 32'o11051276551, 32'o02362132524, 32'o01011540233, 32'o12162531646,
    32'o07056762337, 32'o06631245521, 32'o14164542224, 32'o32633236305, 32'o23342700176,
    32'o02433062234, 32'o15257225043, 32'o26762051606, 32'o00742573230, 32'o05366042132,
    32'o12126416411, 32'o00520471171, 32'o00725646277, 32'o20116577576, 32'o25765742604,
    32'o07633473735, 32'o15674255275, 32'o17555634041, 32'o06503154145, 32'o21576344247,
    32'o14577627653, 32'o02707523333, 32'o34146376720, 32'o30060227734, 32'o13765414060,
    32'o36072251540, 32'o07255221037, 32'o24364674123, 32'o06200353166, 32'o10126373326,
    32'o15664104320, 32'o16401041535, 32'o16215305520, 32'o33115351014, 32'o17411670323
  };

  logic [WORD_W-1:0] lag_words [TABLE_DEPTH];
  logic [IDX_W-1:0]  lead_idx;
  logic [IDX_W-1:0]  trail_idx;
  logic [WORD_W-1:0] expected_words [$];
  int                mismatches;

  task automatic advance_generator(input logic req, input logic [WORD_W-1:0] seed,
                                   output logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] mix;
    logic [IDX_W-1:0]  li;
    logic [IDX_W-1:0]  ti;
    if (req == REQ_DRAW) begin
      li = (lead_idx >= TABLE_DEPTH) ? '0 : lead_idx;
      ti = (trail_idx >= TABLE_DEPTH) ? '0 : trail_idx;
      word = lag_words[li] + lag_words[ti];
      lag_words[li] = word;
      lead_idx  = (li == LAST_IDX) ? '0 : li + 1'b1;
      trail_idx = (ti == LAST_IDX) ? '0 : ti + 1'b1;
    end else begin
      mix = seed;
      lag_words[0] = lag_words[0] + mix;
      // Each step mixes in the word just updated, not its old value.
      for (int i = 1; i < TABLE_DEPTH; i++) begin
        mix = lag_words[i-1] * WORD_W'(MUL_WORD) + mix * WORD_W'(MUL_SEED);
        lag_words[i] = lag_words[i] + mix;
      end
      lead_idx  = IDX_W'(lag_words[0] % WORD_W'(TABLE_DEPTH));
      trail_idx = IDX_W'((WORD_W'(lead_idx) + WORD_W'(TRAIL_OFFSET)) % WORD_W'(TABLE_DEPTH));
      word = '0;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    logic [WORD_W-1:0] predicted;
    logic [WORD_W-1:0] wanted;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        lag_words[i] = START_WORDS[(TABLE_DEPTH-1-i)*WORD_W +: WORD_W];
      end
      lead_idx  = '0;
      trail_idx = '0;
      expected_words.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        advance_generator(in_tuser, in_tdata, predicted);
        expected_words.push_back(predicted);
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          wanted = expected_words.pop_front();
          if (out_tdata !== wanted) begin
            $display("%0t: random_value mismatch, expected %h, actual %h",
                     $time, wanted, out_tdata);
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_words.size();
  end

endmodule

// ===== test/testbench.sv =====
// Stimulus, flow control and verdict for the lagged-Fibonacci generator test.
`timescale 1ns / 100ps

module testbench;
  import rng_req_pkg::*;

  localparam int ITEM_TARGET = 1000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = REQ_DRAW;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  int fail_count;
  int pending_count;
  int items_sent = 0;
  int cycle_count = 0;
  bit steady = 1'b0;
  bit hold_outputs = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  additive_lagged_fibonacci_rng u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rng_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one request and returns at the edge where its transfer happens.
  task automatic offer(input logic req, input logic [31:0] seed);
    steady = (items_sent >= 500 && items_sent < 600) || items_sent >= 880;
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= seed;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic draw_word();
    offer(REQ_DRAW, $urandom);
  endtask

  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic logic [31:0] pick_seed();
    logic [31:0] one_bit;
    one_bit = 32'd1 << $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return one_bit;
      3:       return ~one_bit;
      default: return $urandom;
    endcase
  endfunction

  initial begin : sink
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_outputs && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else if (!steady && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight after reset both indices sit on word 0, so the first draw doubles it.
    draw_word();
    draw_word();
    draw_word();
    offer(REQ_SEED, 32'h0000_0000);
    draw_word();
    draw_word();
    offer(REQ_SEED, 32'hFFFF_FFFF);
    draw_word();
    draw_word();
    offer(REQ_SEED, 32'h0000_0001);
    draw_word();
    offer(REQ_SEED, 32'h8000_0000);
    draw_word();
    offer(REQ_DRAW, 32'hFFFF_FFFF);
    offer(REQ_SEED, 32'h5555_5555);
    draw_word();
    offer(REQ_SEED, 32'hAAAA_AAAA);
    offer(REQ_SEED, 32'h1234_5678);
    draw_word();
    draw_word();
    drain_outputs();

    while (items_sent < ITEM_TARGET) begin
      if (!hold_outputs && items_sent >= 400) begin
        hold_outputs = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 3)) offer(REQ_SEED, pick_seed());
      end else begin
        offer(REQ_SEED, pick_seed());
        repeat ($urandom_range(1, 120)) draw_word();
      end
      if ($urandom_range(0, 7) == 0) begin
        drain_outputs();
      end
    end

    drain_outputs();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/afrng_pkg.sv
hw/rtl/afrng_ram.sv
hw/rtl/afrng_mac.sv
hw/rtl/additive_lagged_fibonacci_rng.sv
hw/rtl/afrng_chk.sv
test/rng_checker.sv
test/testbench.sv
